### rtl/rds_pkg.sv
package rds_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_FRAME_WIDTH    = 3'd0;
    localparam logic [2:0] CFG_FRAME_HEIGHT   = 3'd1;
    localparam logic [2:0] CFG_UV_A_X         = 3'd2;
    localparam logic [2:0] CFG_UV_B_X         = 3'd3;
    localparam logic [2:0] CFG_UV_A_Y         = 3'd4;
    localparam logic [2:0] CFG_UV_B_Y         = 3'd5;
    localparam logic [2:0] CFG_MIN_CONFIDENCE = 3'd6;
    localparam logic [2:0] CFG_USE_CONFIDENCE = 3'd7;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 18;
    localparam int UV_W        = 18;
    localparam int SIZE_REG_W  = 11;
    localparam int DEPTH_W     = 16;
    localparam int CONF_W      = 9;
    localparam int COUNT_W     = 21;
    localparam int DSUM_W      = 36;
    localparam int CSUM_W      = 29;
    localparam int REM_W       = 21;

    // Full confidence and the pass used for a single raw unit
    localparam logic [CONF_W-1:0] CONF_FULL = 9'd510;
    localparam logic [CONF_W-1:0] CONF_ONE  = 9'd255;

    // Rounding offset for the UV-to-pixel mapping (0.5 in Q.16)
    localparam int ROUND_HALF = 32768;

    // Sequencer lengths
    localparam int CALC_STEPS = 6;
    localparam int DIV_STEPS  = 16;
    localparam int STEP_W     = 5;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_code;
        logic               depth_valid;
        logic [7:0]         conf_raw;
        logic               frame_end;
    } in_t;

    typedef struct packed {
        logic               found;
        logic [COUNT_W-1:0] sample_count;
        logic [DEPTH_W-1:0] mean_depth;
        logic [DEPTH_W-1:0] min_depth;
        logic [DEPTH_W-1:0] max_depth;
        logic [CONF_W-1:0]  mean_confidence;
    } out_t;

    typedef enum logic [1:0] {
        ST_CALC,
        ST_RUN,
        ST_DIV,
        ST_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic       calc_load;
        logic [1:0] calc_idx;
        logic       pix_take;
        logic       div_load;
        logic       div_step;
        logic       emit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pix_last;
        logic out_free;
    } sts_t;

endpackage

### rtl/roi_depth_statistics_core.sv
// Depth statistics over a rectangle of a raster-scanned depth frame.
// Input channel (in_valid / in_stall / in_data): one pixel per transfer in
// raster order; frame_end marks the last pixel of a frame.
// Output channel (out_valid / out_stall / out_data): one result per frame,
// sent after the frame_end pixel with count, means, min, max and found.
// Configuration: cfg_write with cfg_index and cfg_data writes one register
// at the clock edge; write only while no frame result is outstanding.
// Throughput: one pixel per cycle inside a frame while no configuration write
// is made. After a frame_end transfer the input stalls while two restoring
// dividers form both means one quotient bit per cycle, and until the output
// register is free to load the result.
// After reset, and after a configuration write in the map or run step, the
// input stalls while one shared multiplier maps the four corners to pixels.
// A receiver stall holds the result in the output register; pixels of the
// next frame keep flowing, and only its frame_end result waits for the slot.
// Reset (rst_n low, asynchronous) restores register defaults and clears the
// accumulators, the raster position and the output valid.
module roi_depth_statistics_core
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [rds_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rds_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  rds_pkg::in_t                    in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output rds_pkg::out_t                   out_data
);

    rds_pkg::cmd_t cmd;
    rds_pkg::sts_t sts;

    // Sequencer
    rds_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .cfg_write (cfg_write),
        .sts       (sts),
        .cmd       (cmd),
        .in_stall  (in_stall)
    );

    // Registers, rectangle mapping, accumulators, dividers, output register
    rds_datapath
    #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    // Hold the input after a frame_end transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.frame_end |=> in_stall)
        else $error("input not held after frame end transfer");

    // Load a new result only while the input is held
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result loaded while pixels were taken");

    // An empty result carries zeros
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.found |->
            out_data.sample_count == '0 && out_data.mean_depth == '0 &&
            out_data.min_depth == '0 && out_data.max_depth == '0 &&
            out_data.mean_confidence == '0)
        else $error("empty result with nonzero fields");

    // A found result has a mean between min and max
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.found |->
            out_data.sample_count != '0 &&
            out_data.min_depth <= out_data.mean_depth &&
            out_data.mean_depth <= out_data.max_depth)
        else $error("found result out of order");

endmodule

### rtl/rds_ctrl.sv
module rds_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          cfg_write,
    input  rds_pkg::sts_t sts,
    output rds_pkg::cmd_t cmd,
    output logic          in_stall
);

    rds_pkg::state_t                 state_reg, state_next;
    logic [rds_pkg::STEP_W-1:0]      step_reg, step_next;

    // State and step registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rds_pkg::ST_CALC;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            rds_pkg::ST_CALC:
            begin
                if (cfg_write)
                begin
                    step_next = '0;
                end
                else if (step_reg == rds_pkg::STEP_W'(rds_pkg::CALC_STEPS - 1))
                begin
                    state_next = rds_pkg::ST_RUN;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            rds_pkg::ST_RUN:
            begin
                if (in_valid && sts.pix_last)
                begin
                    state_next = rds_pkg::ST_DIV;
                    step_next  = '0;
                end
                else if (cfg_write)
                begin
                    state_next = rds_pkg::ST_CALC;
                    step_next  = '0;
                end
            end
            rds_pkg::ST_DIV:
            begin
                if (step_reg == rds_pkg::STEP_W'(rds_pkg::DIV_STEPS))
                begin
                    state_next = rds_pkg::ST_EMIT;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            rds_pkg::ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = rds_pkg::ST_RUN;
                end
            end
            default:
            begin
                state_next = rds_pkg::ST_CALC;
                step_next  = '0;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd          = '0;
        in_stall     = 1'b1;
        cmd.calc_idx = step_reg[1:0];
        case (state_reg)
            rds_pkg::ST_CALC:
            begin
                cmd.calc_load = (step_reg < rds_pkg::STEP_W'(4));
            end
            rds_pkg::ST_RUN:
            begin
                in_stall     = 1'b0;
                cmd.pix_take = in_valid;
            end
            rds_pkg::ST_DIV:
            begin
                cmd.div_load = (step_reg == '0);
                cmd.div_step = (step_reg != '0);
            end
            rds_pkg::ST_EMIT:
            begin
                cmd.emit = sts.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

### rtl/rds_datapath.sv
module rds_datapath
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [rds_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rds_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  rds_pkg::in_t                       in_data,
    input  logic                               out_stall,
    input  rds_pkg::cmd_t                      cmd,
    output rds_pkg::sts_t                      sts,
    output logic                               out_valid,
    output rds_pkg::out_t                      out_data
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int OW  = (XW > YW) ? XW : YW;
    localparam int PRW = rds_pkg::UV_W + OW + 2;
    localparam int QW  = PRW - 16;

    // Configuration registers
    logic [rds_pkg::SIZE_REG_W-1:0]  fw_reg, fh_reg;
    logic signed [rds_pkg::UV_W-1:0] ua_x_reg, ub_x_reg, ua_y_reg, ub_y_reg;
    logic [rds_pkg::CONF_W-1:0]      minc_reg;
    logic                            usec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg   <= 11'd256;
            fh_reg   <= 11'd256;
            ua_x_reg <= 18'sd0;
            ub_x_reg <= 18'sd65536;
            ua_y_reg <= 18'sd0;
            ub_y_reg <= 18'sd65536;
            minc_reg <= '0;
            usec_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rds_pkg::CFG_FRAME_WIDTH:    fw_reg   <= cfg_data[10:0];
                rds_pkg::CFG_FRAME_HEIGHT:   fh_reg   <= cfg_data[10:0];
                rds_pkg::CFG_UV_A_X:         ua_x_reg <= $signed(cfg_data);
                rds_pkg::CFG_UV_B_X:         ub_x_reg <= $signed(cfg_data);
                rds_pkg::CFG_UV_A_Y:         ua_y_reg <= $signed(cfg_data);
                rds_pkg::CFG_UV_B_Y:         ub_y_reg <= $signed(cfg_data);
                rds_pkg::CFG_MIN_CONFIDENCE: minc_reg <= cfg_data[8:0];
                rds_pkg::CFG_USE_CONFIDENCE: usec_reg <= cfg_data[0];
                default:                     usec_reg <= usec_reg;
            endcase
        end
    end

    // Effective frame size: zero acts as one, large values clamp to the maximum
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [XW-1:0] wm1;
    logic [YW-1:0] hm1;

    always_comb
    begin
        if (fw_reg == '0)
            w_eff = WW'(1);
        else if (int'(fw_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(fw_reg);
        if (fh_reg == '0)
            h_eff = HW'(1);
        else if (int'(fh_reg) > MAX_HEIGHT)
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(fh_reg);
    end

    assign wm1 = XW'(w_eff - 1'b1);
    assign hm1 = YW'(h_eff - 1'b1);

    // Rectangle stage A: order the corners and pick one operand pair
    logic signed [rds_pkg::UV_W-1:0] lo_x, hi_x, lo_y, hi_y, sel_uv;
    logic [OW-1:0]                   sel_sm1;

    assign lo_x = (ua_x_reg < ub_x_reg) ? ua_x_reg : ub_x_reg;
    assign hi_x = (ua_x_reg < ub_x_reg) ? ub_x_reg : ua_x_reg;
    assign lo_y = (ua_y_reg < ub_y_reg) ? ua_y_reg : ub_y_reg;
    assign hi_y = (ua_y_reg < ub_y_reg) ? ub_y_reg : ua_y_reg;

    always_comb
    begin
        case (cmd.calc_idx)
            2'd0:
            begin
                sel_uv  = lo_x;
                sel_sm1 = OW'(wm1);
            end
            2'd1:
            begin
                sel_uv  = hi_x;
                sel_sm1 = OW'(wm1);
            end
            2'd2:
            begin
                sel_uv  = lo_y;
                sel_sm1 = OW'(hm1);
            end
            default:
            begin
                sel_uv  = hi_y;
                sel_sm1 = OW'(hm1);
            end
        endcase
    end

    logic signed [rds_pkg::UV_W-1:0] op_uv_reg;
    logic [OW-1:0]                   op_sm1_reg, b_sm1_reg;
    logic                            a_vld_reg, b_vld_reg;
    logic [1:0]                      a_idx_reg, b_idx_reg;
    logic signed [PRW-1:0]           prod_reg, prod_next;
    logic signed [PRW-1:0]           mul_a, mul_b;
    logic [QW-1:0]                   q_val;
    logic [OW-1:0]                   bound_val;
    logic [XW-1:0]                   sx_reg, ex_reg;
    logic [YW-1:0]                   sy_reg, ey_reg;

    // Rectangle stage B: scale by size - 1 and add the rounding half
    assign mul_a     = PRW'(op_uv_reg);
    assign mul_b     = $signed(PRW'(op_sm1_reg));
    assign prod_next = mul_a * mul_b + PRW'(rds_pkg::ROUND_HALF);

    // Rectangle stage C: floor and clamp into the pixel range
    assign q_val = prod_reg[PRW-1:16];

    always_comb
    begin
        if (prod_reg[PRW-1])
            bound_val = '0;
        else if (q_val > QW'(b_sm1_reg))
            bound_val = b_sm1_reg;
        else
            bound_val = q_val[OW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= cmd.calc_load;
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc_load)
        begin
            op_uv_reg  <= sel_uv;
            op_sm1_reg <= sel_sm1;
            a_idx_reg  <= cmd.calc_idx;
        end
        if (a_vld_reg)
        begin
            prod_reg  <= prod_next;
            b_sm1_reg <= op_sm1_reg;
            b_idx_reg <= a_idx_reg;
        end
        if (b_vld_reg)
        begin
            case (b_idx_reg)
                2'd0:    sx_reg <= XW'(bound_val);
                2'd1:    ex_reg <= XW'(bound_val);
                2'd2:    sy_reg <= YW'(bound_val);
                default: ey_reg <= YW'(bound_val);
            endcase
        end
    end

    // Pixel confidence in units of 1/510
    logic [rds_pkg::CONF_W-1:0] conf;

    always_comb
    begin
        if (!usec_reg)
            conf = rds_pkg::CONF_FULL;
        else if (in_data.conf_raw == 8'd1)
            conf = rds_pkg::CONF_ONE;
        else if (in_data.conf_raw inside {[8'd2:8'd12]})
            conf = rds_pkg::CONF_FULL;
        else
            conf = {in_data.conf_raw, 1'b0};
    end

    // Accumulators and raster position
    logic [XW-1:0]                    col_reg;
    logic [YW-1:0]                    row_reg;
    logic [rds_pkg::DSUM_W-1:0]       dsum_reg;
    logic [rds_pkg::CSUM_W-1:0]       csum_reg;
    logic [rds_pkg::COUNT_W-1:0]      cnt_reg;
    logic [rds_pkg::DEPTH_W-1:0]      dmin_reg, dmax_reg;
    logic                             in_roi, qualify, col_wrap, row_wrap;

    assign in_roi = (col_reg >= sx_reg) && (col_reg <= ex_reg)
                 && (row_reg >= sy_reg) && (row_reg <= ey_reg);
    assign qualify = in_roi && in_data.depth_valid && (conf >= minc_reg)
                  && !cnt_reg[rds_pkg::COUNT_W-1];
    assign col_wrap = ((WW + 1)'(col_reg) + 1'b1) >= (WW + 1)'(w_eff);
    assign row_wrap = ((HW + 1)'(row_reg) + 1'b1) >= (HW + 1)'(h_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            dsum_reg <= '0;
            csum_reg <= '0;
            cnt_reg  <= '0;
            dmin_reg <= '1;
            dmax_reg <= '0;
        end
        else if (cmd.emit)
        begin
            dsum_reg <= '0;
            csum_reg <= '0;
            cnt_reg  <= '0;
            dmin_reg <= '1;
            dmax_reg <= '0;
        end
        else if (cmd.pix_take)
        begin
            // Accumulate a qualifying pixel
            if (qualify)
            begin
                dsum_reg <= dsum_reg + rds_pkg::DSUM_W'(in_data.depth_code);
                csum_reg <= csum_reg + rds_pkg::CSUM_W'(conf);
                cnt_reg  <= cnt_reg + 1'b1;
                if (in_data.depth_code < dmin_reg)
                    dmin_reg <= in_data.depth_code;
                if (in_data.depth_code > dmax_reg)
                    dmax_reg <= in_data.depth_code;
            end
            // Advance the raster position, restart it at frame end
            if (in_data.frame_end)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (col_wrap)
            begin
                col_reg <= '0;
                row_reg <= row_wrap ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // Restoring dividers, one quotient bit per step for both means
    logic [rds_pkg::REM_W-1:0] rem_d_reg, rem_c_reg, rem_d_next, rem_c_next;
    logic [15:0]               dq_reg, cq_reg;
    logic [rds_pkg::REM_W:0]   t_d, t_c, cnt_ext;
    logic                      ge_d, ge_c;

    assign cnt_ext    = (rds_pkg::REM_W + 1)'(cnt_reg);
    assign t_d        = {rem_d_reg, dq_reg[15]};
    assign t_c        = {rem_c_reg, cq_reg[15]};
    assign ge_d       = t_d >= cnt_ext;
    assign ge_c       = t_c >= cnt_ext;
    assign rem_d_next = ge_d ? rds_pkg::REM_W'(t_d - cnt_ext) : t_d[rds_pkg::REM_W-1:0];
    assign rem_c_next = ge_c ? rds_pkg::REM_W'(t_c - cnt_ext) : t_c[rds_pkg::REM_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            rem_d_reg <= rds_pkg::REM_W'(dsum_reg[rds_pkg::DSUM_W-1:16]);
            dq_reg    <= dsum_reg[15:0];
            rem_c_reg <= rds_pkg::REM_W'(csum_reg[rds_pkg::CSUM_W-1:16]);
            cq_reg    <= csum_reg[15:0];
        end
        else if (cmd.div_step)
        begin
            rem_d_reg <= rem_d_next;
            dq_reg    <= {dq_reg[14:0], ge_d};
            rem_c_reg <= rem_c_next;
            cq_reg    <= {cq_reg[14:0], ge_c};
        end
    end

    // Output register
    logic          out_valid_reg;
    rds_pkg::out_t out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (cnt_reg == '0)
            begin
                out_reg <= '0;
            end
            else
            begin
                out_reg.found           <= 1'b1;
                out_reg.sample_count    <= cnt_reg;
                out_reg.mean_depth      <= dq_reg;
                out_reg.min_depth       <= dmin_reg;
                out_reg.max_depth       <= dmax_reg;
                out_reg.mean_confidence <= cq_reg[rds_pkg::CONF_W-1:0];
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_data     = out_reg;
    assign sts.out_free = !out_valid_reg || !out_stall;
    assign sts.pix_last = in_data.frame_end;

endmodule

### tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;
    localparam int COUNT_CAP = 1048576;
    localparam int RAW_UNIT_TOP = 12;
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_PIXELS = 400;
    localparam int RANDOM_FRAMES = 25;
    localparam int unsigned RUN_LIMIT_NS = 5_000_000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [rds_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [rds_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    rds_pkg::in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    rds_pkg::out_t out_data;

    // Register copy used by the statistics predictor
    logic [rds_pkg::SIZE_REG_W-1:0] reg_width;
    logic [rds_pkg::SIZE_REG_W-1:0] reg_height;
    logic signed [rds_pkg::UV_W-1:0] reg_ax;
    logic signed [rds_pkg::UV_W-1:0] reg_bx;
    logic signed [rds_pkg::UV_W-1:0] reg_ay;
    logic signed [rds_pkg::UV_W-1:0] reg_by;
    logic [rds_pkg::CONF_W-1:0] reg_min_conf;
    logic reg_use_conf;

    // Raster position and accumulators of the predictor
    int scan_col;
    int scan_row;
    longint acc_depth;
    longint acc_conf;
    int acc_count;
    int seen_min;
    int seen_max;

    rds_pkg::out_t pending_stats[$];

    int tx_gap_max = 10;
    int rx_gap_max = 10;
    int rx_hold = 0;
    bit rx_free_run = 1'b0;

    int pixels_sent = 0;
    int frames_predicted = 0;
    int frames_checked = 0;
    int settings_applied = 0;
    int mismatch_count = 0;

    roi_depth_statistics_core
    #(
        .MAX_WIDTH  (MAX_COLS),
        .MAX_HEIGHT (MAX_ROWS)
    )
    uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    function automatic int draw_wait(input int max_v);
        return (max_v == 0) ? 0 : $urandom_range(max_v, 0);
    endfunction

    // Zero acts as one, anything above the maximum acts as the maximum
    function automatic int live_size(input logic [rds_pkg::SIZE_REG_W-1:0] v,
                                     input int max_v);
        if (v == 0)
            return 1;
        if (int'(v) > max_v)
            return max_v;
        return int'(v);
    endfunction

    // Scale a Q2.16 corner by size-1, round half up, clamp into the frame
    function automatic int uv_to_col(input logic signed [rds_pkg::UV_W-1:0] uv,
                                     input int size);
        longint scaled;
        scaled = longint'(uv) * longint'(size - 1) + longint'(rds_pkg::ROUND_HALF);
        if (scaled < 0)
            return 0;
        scaled = scaled >>> 16;
        if (scaled > longint'(size - 1))
            return size - 1;
        return int'(scaled);
    endfunction

    task automatic clear_scan();
        scan_col = 0;
        scan_row = 0;
        acc_depth = 0;
        acc_conf = 0;
        acc_count = 0;
        seen_min = (1 << rds_pkg::DEPTH_W) - 1;
        seen_max = 0;
    endtask

    task automatic load_defaults();
        reg_width = 11'd256;
        reg_height = 11'd256;
        reg_ax = 18'sd0;
        reg_bx = 18'sd65536;
        reg_ay = 18'sd0;
        reg_by = 18'sd65536;
        reg_min_conf = '0;
        reg_use_conf = 1'b0;
        clear_scan();
    endtask

    // Fold one accepted pixel into the running frame statistics
    task automatic roi_predict(input rds_pkg::in_t px);
        int cols;
        int rows;
        int x0;
        int x1;
        int y0;
        int y1;
        int conf;
        int raw;
        bit in_rect;
        rds_pkg::out_t stats;
        cols = live_size(reg_width, MAX_COLS);
        rows = live_size(reg_height, MAX_ROWS);
        x0 = uv_to_col((reg_ax < reg_bx) ? reg_ax : reg_bx, cols);
        x1 = uv_to_col((reg_ax < reg_bx) ? reg_bx : reg_ax, cols);
        y0 = uv_to_col((reg_ay < reg_by) ? reg_ay : reg_by, rows);
        y1 = uv_to_col((reg_ay < reg_by) ? reg_by : reg_ay, rows);
        raw = int'(px.conf_raw);
        if (!reg_use_conf)
            conf = int'(rds_pkg::CONF_FULL);
        else if (raw >= 1 && raw <= RAW_UNIT_TOP)
            conf = (raw * int'(rds_pkg::CONF_ONE) > int'(rds_pkg::CONF_FULL))
                 ? int'(rds_pkg::CONF_FULL) : raw * int'(rds_pkg::CONF_ONE);
        else
            conf = raw * 2;
        in_rect = scan_col >= x0 && scan_col <= x1 && scan_row >= y0 && scan_row <= y1;

        if (in_rect && px.depth_valid && conf >= int'(reg_min_conf) && acc_count < COUNT_CAP)
        begin
            acc_depth += longint'(px.depth_code);
            acc_conf += longint'(conf);
            acc_count++;
            if (int'(px.depth_code) < seen_min)
                seen_min = int'(px.depth_code);
            if (int'(px.depth_code) > seen_max)
                seen_max = int'(px.depth_code);
        end

        if (px.frame_end)
        begin
            stats = '0;
            if (acc_count > 0)
            begin
                stats.found = 1'b1;
                stats.sample_count = rds_pkg::COUNT_W'(acc_count);
                stats.mean_depth = rds_pkg::DEPTH_W'(acc_depth / acc_count);
                stats.min_depth = rds_pkg::DEPTH_W'(seen_min);
                stats.max_depth = rds_pkg::DEPTH_W'(seen_max);
                stats.mean_confidence = rds_pkg::CONF_W'(acc_conf / acc_count);
            end
            pending_stats.push_back(stats);
            frames_predicted++;
            clear_scan();
        end
        else if (scan_col + 1 >= cols)
        begin
            scan_col = 0;
            scan_row = (scan_row + 1 >= rows) ? 0 : scan_row + 1;
        end
        else
        begin
            scan_col++;
        end
    endtask

    function automatic rds_pkg::in_t make_pixel(input int depth, input bit valid,
                                                input int raw, input bit last);
        rds_pkg::in_t px;
        px.depth_code = rds_pkg::DEPTH_W'(depth);
        px.depth_valid = valid;
        px.conf_raw = 8'(raw);
        px.frame_end = last;
        return px;
    endfunction

    function automatic rds_pkg::in_t random_pixel(input bit last);
        int depth;
        int raw;
        case ($urandom_range(7, 0))
            0: depth = 0;
            1: depth = 65535;
            default: depth = $urandom_range(65535, 0);
        endcase
        raw = ($urandom_range(9, 0) < 3) ? $urandom_range(13, 0) : $urandom_range(255, 0);
        return make_pixel(depth, $urandom_range(4, 0) != 0, raw, last);
    endfunction

    // Hold the pixel until the transfer, then predict its effect
    task automatic send_pixel(input rds_pkg::in_t px);
        int gap;
        gap = draw_wait(tx_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= px;
        do
            @(posedge clk);
        while (in_stall);
        pixels_sent++;
        roi_predict(px);
    endtask

    // Drop valid, wait out every expected result and the block's own latency
    task automatic drain_and_idle();
        in_valid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [rds_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [rds_pkg::CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            rds_pkg::CFG_FRAME_WIDTH:    reg_width = val[rds_pkg::SIZE_REG_W-1:0];
            rds_pkg::CFG_FRAME_HEIGHT:   reg_height = val[rds_pkg::SIZE_REG_W-1:0];
            rds_pkg::CFG_UV_A_X:         reg_ax = val;
            rds_pkg::CFG_UV_B_X:         reg_bx = val;
            rds_pkg::CFG_UV_A_Y:         reg_ay = val;
            rds_pkg::CFG_UV_B_Y:         reg_by = val;
            rds_pkg::CFG_MIN_CONFIDENCE: reg_min_conf = val[rds_pkg::CONF_W-1:0];
            rds_pkg::CFG_USE_CONFIDENCE: reg_use_conf = val[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_rect(input logic [rds_pkg::CFG_DATA_W-1:0] ax,
                              input logic [rds_pkg::CFG_DATA_W-1:0] bx,
                              input logic [rds_pkg::CFG_DATA_W-1:0] ay,
                              input logic [rds_pkg::CFG_DATA_W-1:0] by);
        write_reg(rds_pkg::CFG_UV_A_X, ax);
        write_reg(rds_pkg::CFG_UV_B_X, bx);
        write_reg(rds_pkg::CFG_UV_A_Y, ay);
        write_reg(rds_pkg::CFG_UV_B_Y, by);
    endtask

    task automatic check_field(input string fname, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    task automatic check_result(input rds_pkg::out_t got);
        rds_pkg::out_t want;
        if (pending_stats.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual count %0d",
                     $time, got.sample_count);
            mismatch_count++;
        end
        else
        begin
            want = pending_stats.pop_front();
            frames_checked++;
            check_field("found", want.found, got.found);
            check_field("sample_count", want.sample_count, got.sample_count);
            check_field("mean_depth", want.mean_depth, got.mean_depth);
            check_field("min_depth", want.min_depth, got.min_depth);
            check_field("max_depth", want.max_depth, got.max_depth);
            check_field("mean_confidence", want.mean_confidence, got.mean_confidence);
        end
    endtask

    // Check each result transfer and pace the receiver stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                check_result(out_data);
                rx_hold = draw_wait(rx_gap_max);
                rx_free_run = $urandom_range(1, 0);
            end
            else if (rx_hold > 0 && (out_valid || rx_free_run))
            begin
                rx_hold--;
            end
            out_stall <= (rx_hold > 0);
        end
    end

    // Default registers: full frame, confidence ignored
    task automatic test_reset_defaults();
        send_pixel(make_pixel(0, 1'b1, 0, 1'b0));
        send_pixel(make_pixel(65535, 1'b1, 255, 1'b0));
        send_pixel(make_pixel(1234, 1'b0, 7, 1'b1));
        send_pixel(make_pixel(777, 1'b0, 0, 1'b1));
    endtask

    // Confidence mapping, including the low raw codes and the top threshold
    task automatic test_confidence_map();
        drain_and_idle();
        write_reg(rds_pkg::CFG_FRAME_WIDTH, 18'd16);
        write_reg(rds_pkg::CFG_FRAME_HEIGHT, 18'd1);
        write_reg(rds_pkg::CFG_USE_CONFIDENCE, 18'd1);
        write_reg(rds_pkg::CFG_MIN_CONFIDENCE, 18'd0);
        send_pixel(make_pixel(100, 1'b1, 0, 1'b0));
        send_pixel(make_pixel(200, 1'b1, 1, 1'b0));
        send_pixel(make_pixel(300, 1'b1, 2, 1'b0));
        send_pixel(make_pixel(400, 1'b1, 13, 1'b0));
        send_pixel(make_pixel(500, 1'b1, 255, 1'b1));
        drain_and_idle();
        write_reg(rds_pkg::CFG_MIN_CONFIDENCE, 18'd510);
        send_pixel(make_pixel(600, 1'b1, 254, 1'b0));
        send_pixel(make_pixel(700, 1'b1, 2, 1'b1));
    endtask

    // Swapped corners, exact half rounding and clamping on the vertical axis
    task automatic test_rect_rounding();
        drain_and_idle();
        write_reg(rds_pkg::CFG_USE_CONFIDENCE, 18'd0);
        write_reg(rds_pkg::CFG_MIN_CONFIDENCE, 18'd0);
        write_reg(rds_pkg::CFG_FRAME_WIDTH, 18'd3);
        write_reg(rds_pkg::CFG_FRAME_HEIGHT, 18'd2);
        write_rect(18'd49151, 18'd16384, 18'h1FFFF, 18'h20000);
        for (int i = 0; i < 6; i++)
            send_pixel(make_pixel(1000 * (i + 1), 1'b1, 0, i == 5));
    endtask

    // Width zero acts as one, height above the maximum is limited
    task automatic test_size_extremes();
        drain_and_idle();
        write_reg(rds_pkg::CFG_FRAME_WIDTH, 18'd0);
        write_reg(rds_pkg::CFG_FRAME_HEIGHT, 18'd2047);
        write_rect(18'h20000, 18'h1FFFF, 18'd0, 18'd200);
        send_pixel(make_pixel(42, 1'b1, 0, 1'b0));
        send_pixel(make_pixel(43, 1'b1, 0, 1'b1));
    endtask

    // Shrink the width mid-frame so the position lies past the rectangle
    task automatic test_shrink_midframe();
        drain_and_idle();
        write_reg(rds_pkg::CFG_FRAME_WIDTH, 18'd8);
        write_reg(rds_pkg::CFG_FRAME_HEIGHT, 18'd1);
        write_rect(18'd0, 18'd65536, 18'd0, 18'd65536);
        for (int i = 0; i < 4; i++)
            send_pixel(make_pixel(50 + i, 1'b1, 0, 1'b0));
        drain_and_idle();
        write_reg(rds_pkg::CFG_FRAME_WIDTH, 18'd2);
        send_pixel(make_pixel(9, 1'b1, 0, 1'b0));
        send_pixel(make_pixel(11, 1'b1, 0, 1'b1));
    endtask

    function automatic logic [rds_pkg::CFG_DATA_W-1:0] pick_size();
        case ($urandom_range(9, 0))
            0: return 18'd0;
            1: return 18'd1024;
            2: return 18'd2047;
            3: return 18'($urandom_range(2047, 0));
            default: return 18'($urandom_range(6, 1));
        endcase
    endfunction

    function automatic logic [rds_pkg::CFG_DATA_W-1:0] pick_uv();
        if ($urandom_range(3, 0) == 0)
            return 18'($urandom);
        return 18'($urandom_range(72000, 0)) - 18'd4000;
    endfunction

    // Random register settings, mostly whole frames with random pixels
    task automatic test_random_frames();
        int pixel_base;
        int frame_base;
        int frame_len;
        int area;
        pixel_base = pixels_sent;
        frame_base = frames_predicted;
        while (pixels_sent - pixel_base < RANDOM_PIXELS ||
               frames_predicted - frame_base < RANDOM_FRAMES)
        begin
            drain_and_idle();
            write_reg(rds_pkg::CFG_FRAME_WIDTH, pick_size());
            write_reg(rds_pkg::CFG_FRAME_HEIGHT, pick_size());
            write_rect(pick_uv(), pick_uv(), pick_uv(), pick_uv());
            write_reg(rds_pkg::CFG_MIN_CONFIDENCE,
                      ($urandom_range(2, 0) == 0) ? 18'd0 : 18'($urandom_range(511, 0)));
            write_reg(rds_pkg::CFG_USE_CONFIDENCE, 18'($urandom_range(1, 0)));
            settings_applied++;
            tx_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 10;
            rx_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 10;
            repeat ($urandom_range(4, 1))
            begin
                area = live_size(reg_width, MAX_COLS) * live_size(reg_height, MAX_ROWS);
                if ($urandom_range(3, 0) != 0 && area <= 64)
                    frame_len = area;
                else
                    frame_len = $urandom_range(40, 1);
                for (int i = 0; i < frame_len; i++)
                    send_pixel(random_pixel(i == frame_len - 1));
            end
        end
    endtask

    initial
    begin
        load_defaults();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);

        test_reset_defaults();
        test_confidence_map();
        test_rect_rounding();
        test_size_extremes();
        test_shrink_midframe();
        test_random_frames();
        drain_and_idle();

        $display("run covered %0d pixels, %0d frame results checked, %0d random settings",
                 pixels_sent, frames_checked, settings_applied);
        $display("mismatches found: %0d", mismatch_count);
        if (mismatch_count == 0 && pending_stats.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // End a run that hangs
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("timeout with %0d results outstanding", pending_stats.size());
        $display("status: fail");
        $finish;
    end

endmodule
